// ===== hw/rtl/pif_pkg.sv =====
// Shared types, codes and helpers for the piecewise linear interpolator.
// Used by the front, divider, back, top and checker modules; has no dependencies of its own.
`timescale 1ns / 1ps

package pif_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int DATA_W          = 32;
  localparam int DIFF_W          = DATA_W + 1;
  localparam int PROD_W          = 2 * DIFF_W;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_APPEND,
    CLS_QUERY,
    CLS_NONE
  } cls_t;

  typedef struct packed {
    cls_t                      cls;
    logic signed [DATA_W-1:0]  t;
    logic signed [DATA_W-1:0]  v;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  value;
    logic [1:0]                status;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_UGO,
    B_UDIV,
    B_SCAN,
    B_SEND,
    B_RD0,
    B_RD1,
    B_RD2,
    B_PREP,
    B_MUL,
    B_LGO,
    B_LDIV,
    B_FIN,
    B_EMIT
  } bst_t;

  function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] a);
    mag33 = a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
  endfunction

endpackage

// ===== hw/rtl/pif_fifo.sv =====
// Small register queue used between the parts of the interpolator.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module pif_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/pif_front.sv =====
// Front part: accepts items, classifies the operation and queues commands.
// Depends on pif_pkg and pif_fifo.
`timescale 1ns / 1ps

module pif_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [1:0]                      in_operation,
  input  logic signed [pif_pkg::DATA_W-1:0] in_sample_time,
  input  logic signed [pif_pkg::DATA_W-1:0] in_sample_value,
  output logic                            cmd_valid,
  output pif_pkg::cmd_t                   cmd,
  input  logic                            cmd_pop
);
  import pif_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.t = in_sample_time;
    cmd_in.v = in_sample_value;
    case (in_operation)
      OP_CLEAR:  cmd_in.cls = CLS_CLEAR;
      OP_APPEND: cmd_in.cls = CLS_APPEND;
      OP_QUERY:  cmd_in.cls = CLS_QUERY;
      default:   cmd_in.cls = CLS_NONE;
    endcase
  end

  pif_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd)
  );

  assign cmd_valid = !cmd_empty;

endmodule

// ===== hw/rtl/pif_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pif_pkg for its default widths.
`timescale 1ns / 1ps

module pif_div #(
  parameter int NW = pif_pkg::PROD_W,
  parameter int DW = pif_pkg::DIFF_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int KW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [KW-1:0] cnt_r;
  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == KW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule

// ===== hw/rtl/pif_back.sv =====
// Back part: breakpoint memories, segment search and serial interpolation.
// Depends on pif_pkg and pif_div.
`timescale 1ns / 1ps

module pif_back #(
  parameter int TABLE_DEPTH = pif_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  pif_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_space,
  output logic          res_push,
  output pif_pkg::res_t res
);
  import pif_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = $clog2(DIFF_W);
  localparam int KW = 36;

  bst_t state_r, state_nxt;

  logic signed [DATA_W-1:0] time_mem  [TABLE_DEPTH];
  logic signed [DATA_W-1:0] value_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] t_rd_r, v_rd_r;
  logic [AW-1:0]            rd_addr;

  logic [CW-1:0]            count_r;
  logic                     uniform_r;
  logic signed [DATA_W-1:0] t0_r, v0_r, tl_r, vl_r, x_r;
  logic signed [DIFF_W-1:0] ldt_r, dt0_r;
  logic [AW-1:0]            seg_r, scan_addr_r, scan_tag_r;
  logic                     scan_vld_r, found_r;
  logic signed [DATA_W-1:0] prev_t_r;
  logic signed [DATA_W-1:0] ta_r, va_r, tb_r, vb_r;
  logic [PROD_W-1:0]        mc_r, acc_r;
  logic [DIFF_W-1:0]        mp_r, dt_mag_r, q_r;
  logic [MW-1:0]            mcnt_r;
  logic                     neg_r;
  logic signed [DATA_W-1:0] res_val_r;
  logic [1:0]               res_st_r;

  logic                     go, is_full, hit, found_now;
  logic signed [DIFF_W-1:0] app_diff, xd_w, dt_w, dx_w, dv_w;
  logic signed [KW-1:0]     k_w, nm1_w;
  logic [KW-1:0]            qm_w;
  logic [AW-1:0]            seg_now;

  logic                     div_start, div_done;
  logic [PROD_W-1:0]        div_num, div_quo;
  logic [DIFF_W-1:0]        div_den, div_rem;

  logic [DIFF_W:0]          dmr_w, q34_w;
  logic                     round_up;
  logic signed [DIFF_W+1:0] s_w, sum_w;

  assign go       = (state_r == B_IDLE) && cmd_valid && res_space;
  assign is_full  = (count_r == CW'(TABLE_DEPTH));
  assign app_diff = {cmd.t[DATA_W-1], cmd.t} - {tl_r[DATA_W-1], tl_r};
  assign xd_w     = {x_r[DATA_W-1], x_r} - {t0_r[DATA_W-1], t0_r};
  assign dt_w     = {tb_r[DATA_W-1], tb_r} - {ta_r[DATA_W-1], ta_r};
  assign dx_w     = {x_r[DATA_W-1], x_r} - {ta_r[DATA_W-1], ta_r};
  assign dv_w     = {vb_r[DATA_W-1], vb_r} - {va_r[DATA_W-1], va_r};

  // Floor of the uniform division from the magnitude quotient and remainder.
  assign qm_w  = {{(KW-34){1'b0}}, div_quo[33:0]};
  assign k_w   = (xd_w[DIFF_W-1] ^ dt0_r[DIFF_W-1]) ?
                 -$signed(qm_w + KW'(div_rem != '0)) : $signed(qm_w);
  assign nm1_w = $signed({{(KW-CW){1'b0}}, count_r}) - KW'(1);

  assign hit = scan_vld_r && (scan_tag_r != '0) && (prev_t_r <= x_r) && (t_rd_r >= x_r);
  assign found_now = found_r || hit;
  assign seg_now   = scan_tag_r - 1'b1;

  assign dmr_w    = {1'b0, dt_mag_r} - {1'b0, div_rem};
  assign round_up = ({1'b0, div_rem} >= dmr_w);
  assign q34_w    = {1'b0, div_quo[DIFF_W-1:0]} + (DIFF_W+1)'(round_up);
  assign s_w      = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign sum_w    = $signed({{3{va_r[DATA_W-1]}}, va_r}) + s_w;

  pif_div #(
    .NW (PROD_W),
    .DW (DIFF_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (go) begin
          state_nxt = B_EMIT;
          if (cmd.cls == CLS_QUERY && count_r > CW'(1)) begin
            if (uniform_r) begin
              if (dt0_r != '0) state_nxt = B_UGO;
            end else if (!(cmd.t < t0_r) && !(cmd.t > tl_r)) begin
              state_nxt = B_SCAN;
            end
          end
        end
      end
      B_UGO:  state_nxt = B_UDIV;
      B_UDIV: begin
        if (div_done) begin
          state_nxt = (k_w >= nm1_w || k_w < 0) ? B_EMIT : B_RD0;
        end
      end
      B_SCAN: if (scan_addr_r == AW'(count_r - 1'b1)) state_nxt = B_SEND;
      B_SEND: state_nxt = found_now ? B_RD0 : B_EMIT;
      B_RD0:  state_nxt = B_RD1;
      B_RD1:  state_nxt = B_RD2;
      B_RD2:  state_nxt = B_PREP;
      B_PREP: state_nxt = (dt_w == '0) ? B_EMIT : B_MUL;
      B_MUL:  if (mcnt_r == MW'(DIFF_W - 1)) state_nxt = B_LGO;
      B_LGO:  state_nxt = B_LDIV;
      B_LDIV: if (div_done) state_nxt = B_FIN;
      B_FIN:  state_nxt = B_EMIT;
      B_EMIT: state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = go;
    res_push  = (state_r == B_EMIT);
    res.value = res_val_r;
    res.status = res_st_r;
    div_start = (state_r == B_UGO) || (state_r == B_LGO);
    div_num   = (state_r == B_UGO) ? {{(PROD_W-DIFF_W){1'b0}}, mag33(xd_w)} : acc_r;
    div_den   = (state_r == B_UGO) ? mag33(dt0_r) : dt_mag_r;
    case (state_r)
      B_SCAN:  rd_addr = scan_addr_r;
      B_RD1:   rd_addr = seg_r + 1'b1;
      default: rd_addr = seg_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      count_r   <= '0;
      uniform_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (go && cmd.cls == CLS_CLEAR) begin
        count_r   <= '0;
        uniform_r <= 1'b1;
      end else if (go && cmd.cls == CLS_APPEND && !is_full) begin
        count_r <= count_r + 1'b1;
        if (count_r >= CW'(2) && app_diff != ldt_r) uniform_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && cmd.cls == CLS_APPEND && !is_full) begin
      time_mem[count_r[AW-1:0]]  <= cmd.t;
      value_mem[count_r[AW-1:0]] <= cmd.v;
    end
    t_rd_r <= time_mem[rd_addr];
    v_rd_r <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    scan_vld_r <= (state_r == B_SCAN);
    scan_tag_r <= scan_addr_r;
    if (scan_vld_r) prev_t_r <= t_rd_r;
    if (hit) begin
      found_r <= 1'b1;
      seg_r   <= seg_now;
    end

    case (state_r)
      B_IDLE: begin
        if (go) begin
          x_r         <= cmd.t;
          res_val_r   <= '0;
          res_st_r    <= ST_OK;
          scan_addr_r <= '0;
          found_r     <= 1'b0;
          case (cmd.cls)
            CLS_APPEND: begin
              if (is_full) begin
                res_st_r <= ST_FULL;
              end else begin
                ldt_r <= app_diff;
                tl_r  <= cmd.t;
                vl_r  <= cmd.v;
                if (count_r == '0) begin
                  t0_r <= cmd.t;
                  v0_r <= cmd.v;
                end
                if (count_r == CW'(1)) dt0_r <= app_diff;
              end
            end
            CLS_QUERY: begin
              if (count_r == '0) begin
                res_st_r <= ST_EMPTY;
              end else if (count_r == CW'(1)) begin
                res_val_r <= v0_r;
              end else if (uniform_r) begin
                if (dt0_r == '0) res_st_r <= ST_ZERO;
              end else if (cmd.t < t0_r) begin
                res_val_r <= v0_r;
              end else if (cmd.t > tl_r) begin
                res_val_r <= vl_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      B_UDIV: begin
        if (div_done) begin
          if (k_w >= nm1_w) begin
            res_val_r <= vl_r;
          end else if (k_w < 0) begin
            res_val_r <= v0_r;
          end else begin
            seg_r <= k_w[AW-1:0];
          end
        end
      end
      B_SCAN: scan_addr_r <= scan_addr_r + 1'b1;
      B_RD1: begin
        ta_r <= t_rd_r;
        va_r <= v_rd_r;
      end
      B_RD2: begin
        tb_r <= t_rd_r;
        vb_r <= v_rd_r;
      end
      B_PREP: begin
        if (dt_w == '0) res_st_r <= ST_ZERO;
        mc_r     <= {{(PROD_W-DIFF_W){1'b0}}, mag33(dv_w)};
        mp_r     <= mag33(dx_w);
        acc_r    <= '0;
        mcnt_r   <= '0;
        dt_mag_r <= mag33(dt_w);
        neg_r    <= dv_w[DIFF_W-1] ^ dx_w[DIFF_W-1] ^ dt_w[DIFF_W-1];
      end
      B_MUL: begin
        if (mp_r[0]) acc_r <= acc_r + mc_r;
        mc_r   <= {mc_r[PROD_W-2:0], 1'b0};
        mp_r   <= {1'b0, mp_r[DIFF_W-1:1]};
        mcnt_r <= mcnt_r + 1'b1;
      end
      B_LDIV: begin
        if (div_done) q_r <= q34_w[DIFF_W] ? '1 : q34_w[DIFF_W-1:0];
      end
      B_FIN: begin
        if (sum_w[DIFF_W+1:DATA_W-1] != {4{sum_w[DIFF_W+1]}}) begin
          res_val_r <= sum_w[DIFF_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} :
                                         {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
          res_val_r <= sum_w[DATA_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/piecewise_linear_interpolator.sv =====
// Channel   Handshake          Payload
// in_       in_push / in_full  in_operation, in_sample_time, in_sample_value
// out_      out_pop / out_empty out_result_value, out_status
//
// Clear, append, unused operations and queries answered without arithmetic go
// straight to the result in the back part. A uniform query that interpolates runs
// two 66-step divisions and the 33-step multiply; one that clamps runs only the
// first division. A scanned query reads every stored point and, once a segment is
// found, runs the multiply and one division. Reset is synchronous and empties both
// queues; the memories need no clearing. Either side may stall independently.
//
// Top level: command queue, execution back end and result queue.
// Depends on pif_pkg, pif_front, pif_back and pif_fifo.
`timescale 1ns / 1ps

module piecewise_linear_interpolator #(
  parameter int TABLE_DEPTH = pif_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [1:0]                        in_operation,
  input  logic signed [pif_pkg::DATA_W-1:0] in_sample_time,
  input  logic signed [pif_pkg::DATA_W-1:0] in_sample_value,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [pif_pkg::DATA_W-1:0] out_result_value,
  output logic [1:0]                        out_status
);
  import pif_pkg::*;

  logic cmd_valid, cmd_pop, res_push, res_full;
  cmd_t cmd;
  res_t res, res_out;

  pif_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_sample_time  (in_sample_time),
    .in_sample_value (in_sample_value),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  pif_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_space (!res_full),
    .res_push  (res_push),
    .res       (res)
  );

  pif_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_out)
  );

  assign out_result_value = res_out.value;
  assign out_status       = res_out.status;

endmodule

// ===== hw/rtl/pif_checker.sv =====
// Port-level checks for the piecewise linear interpolator, bound to the top.
// Depends on pif_pkg and piecewise_linear_interpolator.
`timescale 1ns / 1ps

module pif_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic signed [pif_pkg::DATA_W-1:0] out_result_value,
  input logic [1:0]                        out_status
);
  import pif_pkg::*;

  // A result with a status other than OK never carries a value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> (out_result_value == '0))
    else $error("nonzero value with error status");

  // A waiting result holds until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result_value)
                                  && $stable(out_status)))
    else $error("waiting result changed");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input side full after reset");

endmodule

bind piecewise_linear_interpolator pif_checker u_pif_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);
